// File: sv/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// shared types and constants of the stego message extractor: transaction
// payloads, register map codes and configuration layout
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int MAX_DIM     = 512;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 4;
    localparam int CHUNK_LOG_W = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // register indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_CHUNK_SIZE_LOG2 = 2'd0,
        REG_PIXEL_SPACING   = 2'd1,
        REG_IMAGE_ROWS      = 2'd2,
        REG_IMAGE_COLS      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CHUNK_LOG_W-1:0] chunk_size_log2;
        logic [DIM_W-1:0]       pixel_spacing;
        logic [DIM_W-1:0]       image_rows;
        logic [DIM_W-1:0]       image_cols;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] original_pixel;
        logic [BYTE_W-1:0] stego_pixel;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] message_byte;
        logic              is_end;
    } t_out_item;

    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_step_res;

endpackage

// File: sv/smx_frame.sv
// ----------------------------------------------------------------------------
// smx_frame
// raster position tracking, carrier grid detection and byte packing for one
// pixel pair per step
// ----------------------------------------------------------------------------
module smx_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smx_pkg::t_cfg     i_cfg,
    input  logic              i_step,
    input  smx_pkg::t_in_item i_item,
    output smx_pkg::t_step_res o_res
);

    localparam int IDX_W  = smx_pkg::IDX_W;
    localparam int DIM_W  = smx_pkg::DIM_W;
    localparam int BYTE_W = smx_pkg::BYTE_W;
    localparam int OFF_W  = smx_pkg::OFF_W;

    logic [IDX_W-1:0]  r_row, r_col, r_row_phase, r_col_phase;
    logic [BYTE_W-1:0] r_acc;
    logic [OFF_W-1:0]  r_off;
    logic              r_done;

    logic [IDX_W-1:0]  n_row, n_col, n_row_phase, n_col_phase;
    logic [BYTE_W-1:0] n_acc;
    logic [OFF_W-1:0]  n_off;
    logic              n_done;

    logic [IDX_W-1:0]    eff_row, eff_col, eff_row_phase, eff_col_phase;
    logic [BYTE_W-1:0]   eff_acc;
    logic [OFF_W-1:0]    eff_off;
    logic                eff_done;
    logic [DIM_W-1:0]    rows, cols, sp, sp_m1;
    logic [DIM_W-1:0]    row_inc, col_inc, row_ph_inc, col_ph_inc;
    logic                carrier;
    logic [BYTE_W-1:0]   diff, mask, chunk, acc_sum;
    logic [2*BYTE_W-1:0] shifted;
    logic [OFF_W-1:0]    bits, off_sum;

    // size 0 acts as 1, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(smx_pkg::MAX_DIM)) begin
            r = DIM_W'(smx_pkg::MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        // frame start clears the frame state before the pixel is used
        eff_row       = i_item.frame_start ? '0 : r_row;
        eff_col       = i_item.frame_start ? '0 : r_col;
        eff_row_phase = i_item.frame_start ? '0 : r_row_phase;
        eff_col_phase = i_item.frame_start ? '0 : r_col_phase;
        eff_acc       = i_item.frame_start ? '0 : r_acc;
        eff_off       = i_item.frame_start ? '0 : r_off;
        eff_done      = i_item.frame_start ? 1'b0 : r_done;

        rows  = clamp_dim(i_cfg.image_rows);
        cols  = clamp_dim(i_cfg.image_cols);
        sp    = i_cfg.pixel_spacing;
        sp_m1 = sp - DIM_W'(1);

        row_inc    = {1'b0, eff_row} + DIM_W'(1);
        col_inc    = {1'b0, eff_col} + DIM_W'(1);
        row_ph_inc = {1'b0, eff_row_phase} + DIM_W'(1);
        col_ph_inc = {1'b0, eff_col_phase} + DIM_W'(1);

        // carrier grid point, but not the parameter pixel at the grid origin
        carrier = (sp != '0)
               && ({1'b0, eff_row_phase} == sp_m1)
               && ({1'b0, eff_col_phase} == sp_m1)
               && !(({1'b0, eff_row} == sp_m1) && ({1'b0, eff_col} == sp_m1));

        unique case (i_cfg.chunk_size_log2)
            2'd0: mask = 8'h01;
            2'd1: mask = 8'h03;
            2'd2: mask = 8'h0F;
            2'd3: mask = 8'hFF;
            default: mask = 8'h01;
        endcase
        bits    = OFF_W'(1) << i_cfg.chunk_size_log2;
        diff    = i_item.stego_pixel - i_item.original_pixel;
        chunk   = diff & mask;
        shifted = {{BYTE_W{1'b0}}, chunk} << eff_off[2:0];
        acc_sum = eff_acc | shifted[BYTE_W-1:0];
        off_sum = eff_off + bits;

        n_row       = eff_row;
        n_col       = eff_col;
        n_row_phase = eff_row_phase;
        n_col_phase = eff_col_phase;
        n_acc       = eff_acc;
        n_off       = eff_off;
        n_done      = eff_done;
        o_res       = '0;

        if (!eff_done) begin
            if (carrier) begin
                if (off_sum >= OFF_W'(BYTE_W)) begin
                    o_res.emit              = 1'b1;
                    o_res.item.message_byte = acc_sum;
                    o_res.item.is_end       = (acc_sum == '0);
                    n_done                  = (acc_sum == '0);
                    n_acc                   = '0;
                    n_off                   = '0;
                end else begin
                    n_acc = acc_sum;
                    n_off = off_sum;
                end
            end

            priority if ((row_inc >= rows) && (col_inc >= cols)) begin
                n_done = 1'b1;
            end else if (col_inc >= cols) begin
                n_col       = '0;
                n_col_phase = '0;
                n_row       = row_inc[IDX_W-1:0];
                n_row_phase = (row_ph_inc >= sp) ? '0 : row_ph_inc[IDX_W-1:0];
            end else begin
                n_col       = col_inc[IDX_W-1:0];
                n_col_phase = (col_ph_inc >= sp) ? '0 : col_ph_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_row_phase <= '0;
            r_col_phase <= '0;
            r_acc       <= '0;
            r_off       <= '0;
            r_done      <= 1'b0;
        end else if (i_step) begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_phase <= n_row_phase;
            r_col_phase <= n_col_phase;
            r_acc       <= n_acc;
            r_off       <= n_off;
            r_done      <= n_done;
        end
    end

    // terminator stops the message until the next frame start
    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.emit && o_res.item.is_end) |=> r_done)
        else $error("terminator did not end the message");

    // a full byte is always flushed on the step that completes it
    a_off_below_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off < OFF_W'(BYTE_W))
        else $error("bit offset reached a full byte without emitting");

    // phases restart with their index, so never run ahead of it
    a_phase_le_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_phase <= r_col) && (r_row_phase <= r_row))
        else $error("phase counter ahead of position counter");

endmodule

// File: sv/stego_message_extractor_core.sv
// ----------------------------------------------------------------------------
// stego_message_extractor_core
// recovers a message hidden in the low bits of grid-spaced pixels of a stego
// image, given the cover image alongside it
// ----------------------------------------------------------------------------
// Feed one (cover, stego) pixel pair per transaction in raster order, with
// frame_start set on the first pixel of each image. The core takes a new pair
// every clock; each pair is captured in an input register, processed by a
// single-pass step (subtract, mask, shift into the byte, counter updates) and
// any finished byte lands in an output register on the next clock.
// Throughput is one pair per clock and only drops when the output side
// stalls while a result is still held. A zero byte is delivered with
// is_end set, after which pairs are consumed without results until the next
// frame start; the same silence follows the last pixel of the image.
// Program the four registers over the APB port only while the core is idle.
// ----------------------------------------------------------------------------
module stego_message_extractor_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // pixel pair input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  smx_pkg::t_in_item          i_in_data,

    // message byte output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output smx_pkg::t_out_item         o_out_data,

    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [smx_pkg::ADDR_W-1:0] paddr,
    input  logic [smx_pkg::DATA_W-1:0] pwdata,
    output logic [smx_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DIM_W       = smx_pkg::DIM_W;
    localparam int DATA_W      = smx_pkg::DATA_W;
    localparam int CHUNK_LOG_W = smx_pkg::CHUNK_LOG_W;

    smx_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    smx_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    smx_pkg::t_out_item r_out_item;

    smx_pkg::t_step_res w_res;
    logic               out_free;
    logic               advance;
    logic               in_ready;
    logic               cfg_write;

    // ------------------------------------------------------------------------
    // configuration registers, zero wait state
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_size_log2 <= '0;
            r_cfg.pixel_spacing   <= DIM_W'(1);
            r_cfg.image_rows      <= DIM_W'(1);
            r_cfg.image_cols      <= DIM_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                smx_pkg::REG_CHUNK_SIZE_LOG2: begin
                    r_cfg.chunk_size_log2 <= pwdata[CHUNK_LOG_W-1:0];
                end
                smx_pkg::REG_PIXEL_SPACING: begin
                    r_cfg.pixel_spacing <= pwdata[DIM_W-1:0];
                end
                smx_pkg::REG_IMAGE_ROWS: begin
                    r_cfg.image_rows <= pwdata[DIM_W-1:0];
                end
                smx_pkg::REG_IMAGE_COLS: begin
                    r_cfg.image_cols <= pwdata[DIM_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // read back, register values zero extended
    always_comb begin
        unique case (paddr[3:2])
            smx_pkg::REG_CHUNK_SIZE_LOG2: prdata = DATA_W'(r_cfg.chunk_size_log2);
            smx_pkg::REG_PIXEL_SPACING:   prdata = DATA_W'(r_cfg.pixel_spacing);
            smx_pkg::REG_IMAGE_ROWS:      prdata = DATA_W'(r_cfg.image_rows);
            smx_pkg::REG_IMAGE_COLS:      prdata = DATA_W'(r_cfg.image_cols);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // flow control
    // the step runs whenever the output register is empty or being drained;
    // a held result under stall freezes the step, and the input side stalls
    // once the input register is occupied as well
    // ------------------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_ready   = !r_in_valid || out_free;
    assign o_in_stall = !in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // ------------------------------------------------------------------------
    // decode step: position, carrier test and byte packing
    // ------------------------------------------------------------------------
    smx_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_res   (w_res)
    );

    // output register, loaded with whatever the step produced this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && w_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    // the input side only backs up when both stages hold a transaction
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // a byte produced by the step is presented on the next cycle
    a_emit_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && w_res.emit) |=> o_out_valid)
        else $error("produced byte was lost");

    // a stalled byte stays on the output unchanged
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled byte changed or dropped");

endmodule
